// File: hw/rtl/euclidean_distance_accumulator_macros.svh
// Assertion macros shared by the distance accumulator RTL.
`ifndef EUCLIDEAN_DISTANCE_ACCUMULATOR_MACROS_SVH
`define EUCLIDEAN_DISTANCE_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define EDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eda assertion failed");
// Next-cycle implication, disabled during reset
`define EDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eda assertion failed");
`else
`define EDA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/eda_pkg.sv
// Types and constants of the Euclidean distance accumulator.
package eda_pkg;

    localparam int ELEMENT_WIDTH = 16;
    localparam int MAG_WIDTH     = ELEMENT_WIDTH;
    localparam int DIFF_WIDTH    = ELEMENT_WIDTH + 1;
    localparam int SQUARE_WIDTH  = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH     = 42;
    localparam int DIST_WIDTH    = SUM_WIDTH / 2;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;
    // Highest power of four that fits the sum width
    localparam logic [SUM_WIDTH-1:0] SQRT_BIT_INIT = SUM_WIDTH'(1) << (SUM_WIDTH - 2);

    typedef struct packed {
        logic signed [ELEMENT_WIDTH-1:0] element_a;
        logic signed [ELEMENT_WIDTH-1:0] element_b;
        logic                            last_element;
    } t_in_item;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic [SUM_WIDTH-1:0]  sum_squares;
        logic                  overflowed;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_status;

endpackage

// File: hw/rtl/eda_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface eda_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/euclidean_distance_accumulator.sv
// Top level: squared-difference accumulator with iterative root per vector.
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+------------
//  i_in     | in  | element_a, element_b, last_element       | valid/ready
//  o_out    | out | distance, sum_squares, overflowed        | valid/ready
//
// A non-final pair passes capture and difference, square on the
// 16x16 multiplier and saturating add into the 42-bit sum.
// A final pair adds a start state, the single root unit (21 result bits,
// then its registered done) and the load of the output register.
// Reset clears the sum, the saturation flag and the output valid at once.
// A stalled output holds its beat; the next vector accumulates meanwhile and
// waits only when its own result is ready to load.
`include "euclidean_distance_accumulator_macros.svh"

module euclidean_distance_accumulator
    import eda_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    eda_stream_if.sink   i_in,
    eda_stream_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_ROOT_GO,
        S_ROOT,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [SUM_WIDTH-1:0]    r_sum;
    logic                    r_sat;
    logic                    r_out_valid;
    t_out_item               r_out_payload;
    logic [MAG_WIDTH-1:0]    r_mag;
    logic                    r_last;
    logic [SQUARE_WIDTH-1:0] r_square;

    logic signed [DIFF_WIDTH-1:0] n_diff;
    logic [DIFF_WIDTH-1:0]        n_abs;
    logic [SUM_WIDTH:0]           n_sum_ext;
    logic [SUM_WIDTH-1:0]         n_sum;
    logic                         n_sat;
    logic                         w_in_beat;
    logic                         w_out_beat;
    logic                         w_out_free;
    t_sqrt_status                 w_sqrt_status;
    logic [DIST_WIDTH-1:0]        w_root;

    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_out_beat = o_out.valid && o_out.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Difference magnitude of the incoming pair
    always_comb begin
        n_diff = {i_in.payload.element_a[ELEMENT_WIDTH-1], i_in.payload.element_a}
               - {i_in.payload.element_b[ELEMENT_WIDTH-1], i_in.payload.element_b};
        n_abs  = n_diff[DIFF_WIDTH-1] ? (~n_diff + DIFF_WIDTH'(1)) : n_diff;
    end

    // Saturating accumulate of the registered square
    always_comb begin
        n_sum_ext = {1'b0, r_sum} + (SUM_WIDTH+1)'(r_square);
        if (r_sat || n_sum_ext[SUM_WIDTH]) begin
            n_sum = SUM_MAX;
            n_sat = 1'b1;
        end else begin
            n_sum = n_sum_ext[SUM_WIDTH-1:0];
            n_sat = 1'b0;
        end
    end

    eda_sqrt_unit u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_ROOT_GO),
        .i_radicand (r_sum),
        .o_status   (w_sqrt_status),
        .o_root     (w_root)
    );

    // Sequencer, running sum and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_beat) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: r_state <= S_ACCUM;
                S_ACCUM: begin
                    r_sum   <= n_sum;
                    r_sat   <= n_sat;
                    r_state <= r_last ? S_ROOT_GO : S_IDLE;
                end
                S_ROOT_GO: r_state <= S_ROOT;
                S_ROOT: begin
                    if (w_sqrt_status.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_sum   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: operand capture, square, result beat
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_mag  <= n_abs[MAG_WIDTH-1:0];
            r_last <= i_in.payload.last_element;
        end
        if (r_state == S_SQUARE) begin
            r_square <= r_mag * r_mag;
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out_payload.distance    <= w_root;
            r_out_payload.sum_squares <= r_sum;
            r_out_payload.overflowed  <= r_sat;
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_payload;

    // Overflow is only reported with a pinned sum
    `EDA_ASSERT_IMPL(a_ovf_pins_sum, i_clk, i_rst_n, o_out.valid && o_out.payload.overflowed, o_out.payload.sum_squares == SUM_MAX)
    // Emitted root never exceeds the true root
    `EDA_ASSERT_IMPL(a_root_bound, i_clk, i_rst_n, o_out.valid, (64'(o_out.payload.distance) * 64'(o_out.payload.distance)) <= 64'(o_out.payload.sum_squares))
    // Saturation sticks until the vector result is loaded
    `EDA_ASSERT_NEXT(a_sat_sticky, i_clk, i_rst_n, r_sat && r_state != S_EMIT, r_sat)
    // Root unit is busy only while the sequencer waits on it
    `EDA_ASSERT_IMPL(a_root_owned, i_clk, i_rst_n, w_sqrt_status.busy, r_state == S_ROOT)

endmodule

// File: hw/rtl/eda_sqrt_unit.sv
// Iterative floor square root, one result bit per cycle.
module eda_sqrt_unit
    import eda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_WIDTH-1:0]  i_radicand,
    output t_sqrt_status          o_status,
    output logic [DIST_WIDTH-1:0] o_root
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state               r_state;
    logic                 r_done;
    logic [SUM_WIDTH-1:0] r_rem;
    logic [SUM_WIDTH-1:0] r_root;
    logic [SUM_WIDTH-1:0] r_bit;

    logic [SUM_WIDTH:0]   n_trial;
    logic                 n_take;

    // Trial subtract of root plus current bit from the remainder
    always_comb begin
        n_trial = {1'b0, r_root} + {1'b0, r_bit};
        n_take  = ({1'b0, r_rem} >= n_trial);
    end

    // Sequence the iterations and flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_bit[0]) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Load the operand, then advance one digit per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_rem  <= i_radicand;
            r_root <= '0;
            r_bit  <= SQRT_BIT_INIT;
        end else if (r_state == S_RUN) begin
            if (n_take) begin
                r_rem  <= r_rem - n_trial[SUM_WIDTH-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_status.busy = (r_state == S_RUN);
    assign o_status.done = r_done;
    assign o_root        = r_root[DIST_WIDTH-1:0];

endmodule

// File: verif/euclidean_distance_checker.sv
// Checker for the distance accumulator: predicts each vector's result and compares output beats.
module euclidean_distance_checker
    import eda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_beat,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted accumulator state, mirrors the block's running sum
    logic [SUM_WIDTH-1:0] sum_of_squares;
    logic                 sum_saturated;
    t_out_item            distance_queue[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        sum_of_squares = '0;
        sum_saturated  = 1'b0;
    end

    // Floor square root by setting result bits from the top down
    function automatic logic [DIST_WIDTH-1:0] floor_root(input logic [SUM_WIDTH-1:0] value);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = DIST_WIDTH - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= 64'(value)) begin
                root = trial;
            end
        end
        return root[DIST_WIDTH-1:0];
    endfunction

    // Square of the exact difference of one element pair
    function automatic logic [63:0] pair_square(input t_in_item beat);
        logic signed [DIFF_WIDTH-1:0] diff;
        logic [DIFF_WIDTH-1:0]        mag;
        diff = $signed({beat.element_a[ELEMENT_WIDTH-1], beat.element_a})
             - $signed({beat.element_b[ELEMENT_WIDTH-1], beat.element_b});
        mag  = (diff < 0) ? -diff : diff;
        return 64'(mag) * 64'(mag);
    endfunction

    always @(posedge i_clk) begin
        logic [63:0] square;
        t_out_item   result;
        t_out_item   want;
        int          errors;
        errors = 0;
        if (!i_rst_n) begin
            sum_of_squares = '0;
            sum_saturated  = 1'b0;
            distance_queue.delete();
        end else begin
            // Accumulate an accepted input beat, queue a result on the final pair
            if (i_in_valid && i_in_ready) begin
                square = pair_square(i_in_beat);
                if (sum_saturated || square > 64'(SUM_MAX) - 64'(sum_of_squares)) begin
                    sum_of_squares = SUM_MAX;
                    sum_saturated  = 1'b1;
                end else begin
                    sum_of_squares = sum_of_squares + square[SUM_WIDTH-1:0];
                end
                if (i_in_beat.last_element) begin
                    result.distance    = floor_root(sum_of_squares);
                    result.sum_squares = sum_of_squares;
                    result.overflowed  = sum_saturated;
                    distance_queue.push_back(result);
                    sum_of_squares = '0;
                    sum_saturated  = 1'b0;
                end
            end
            // Compare an accepted output beat with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (distance_queue.size() == 0) begin
                    $error("result beat with no vector pending: distance %0d sum %0d",
                           i_out_beat.distance, i_out_beat.sum_squares);
                    errors++;
                end else begin
                    want = distance_queue.pop_front();
                    if (i_out_beat.distance !== want.distance) begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               want.distance, i_out_beat.distance);
                        errors++;
                    end
                    if (i_out_beat.sum_squares !== want.sum_squares) begin
                        $error("sum_squares mismatch: expected %0d, actual %0d",
                               want.sum_squares, i_out_beat.sum_squares);
                        errors++;
                    end
                    if (i_out_beat.overflowed !== want.overflowed) begin
                        $error("overflowed mismatch: expected %0d, actual %0d",
                               want.overflowed, i_out_beat.overflowed);
                        errors++;
                    end
                end
            end
        end
        o_fail_count <= o_fail_count + errors;
        o_pending    <= distance_queue.size();
    end

endmodule

// File: verif/euclidean_distance_accumulator_tb.sv
// Testbench top: drives element pairs and result backpressure, gives the verdict.
module euclidean_distance_accumulator_tb;
    import eda_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASE_PAIRS     = 40;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_VECTOR_LEN = 1030;
    localparam int HOLD_VECTORS    = 4;

    localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MIN = 16'sh8000;

    logic i_clk;
    logic i_rst_n;

    eda_stream_if #(.t_payload(t_in_item))  in_if ();
    eda_stream_if #(.t_payload(t_out_item)) out_if ();

    int  fail_count;
    int  pending_results;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  pairs_sent;
    int  cycle_count;
    bit  hold_request;
    bit  hold_off;

    euclidean_distance_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    euclidean_distance_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_beat    (in_if.payload),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_beat   (out_if.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Abort a hung run
    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Hold off the result side for a long stretch once requested
    initial begin
        hold_off = 1'b0;
        wait (hold_request);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Randomly stall the result side
    always @(posedge i_clk) begin
        if (hold_off) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one pair and hold it until accepted, with random gaps ahead of it
    task automatic send_pair(input logic signed [ELEMENT_WIDTH-1:0] a,
                             input logic signed [ELEMENT_WIDTH-1:0] b,
                             input logic last);
        t_in_item beat;
        beat.element_a    = a;
        beat.element_b    = b;
        beat.last_element = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= beat;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pairs_sent++;
    endtask

    // Element value: mostly full range, some small, some at the extremes
    function automatic logic signed [ELEMENT_WIDTH-1:0] pick_element();
        logic signed [ELEMENT_WIDTH-1:0] value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = ELEMENT_WIDTH'($urandom);
            5, 6, 7:       value = ELEMENT_WIDTH'($urandom_range(0, 1023) - 512);
            default: begin
                case ($urandom_range(0, 3))
                    0:       value = ELEM_MAX;
                    1:       value = ELEM_MIN;
                    2:       value = '0;
                    default: value = '1;
                endcase
            end
        endcase
        return value;
    endfunction

    // Send one vector of random pairs, the final one flagged
    task automatic send_vector(input int length);
        logic signed [ELEMENT_WIDTH-1:0] a;
        logic signed [ELEMENT_WIDTH-1:0] b;
        for (int k = 0; k < length; k++) begin
            a = pick_element();
            b = ($urandom_range(0, 15) == 0) ? a : pick_element();
            send_pair(a, b, k == length - 1);
        end
    endtask

    // Mostly short vectors, a few long ones
    task automatic send_random_vectors(input int pair_count);
        int start;
        int roll;
        start = pairs_sent;
        while (pairs_sent - start < pair_count) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                send_vector($urandom_range(1, 6));
            end else if (roll < 95) begin
                send_vector($urandom_range(7, 40));
            end else begin
                send_vector($urandom_range(41, 120));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        hold_request  = 1'b0;
        pairs_sent    = 0;
        send_idle_pct = 13;
        recv_idle_pct = 83;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-pair vectors at the field extremes and near zero
        send_pair('0, '0, 1'b1);
        send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
        send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
        send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
        send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
        send_pair(16'sd1, '0, 1'b1);
        send_pair('0, 16'sd1, 1'b1);
        send_pair(-16'sd1, '0, 1'b1);
        send_pair(-16'sd256, 16'sd256, 1'b1);
        // Short multi-pair vectors
        send_pair(16'sd256, '0, 1'b0);
        send_pair('0, 16'sd256, 1'b0);
        send_pair(-16'sd512, 16'sd512, 1'b0);
        send_pair(16'sd3, -16'sd4, 1'b1);
        send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
        send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
        send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
        send_pair(ELEM_MIN, ELEM_MAX, 1'b1);

        // Overlong vector that saturates the sum, keep going past it
        for (int k = 0; k < LONG_VECTOR_LEN; k++) begin
            if (k[0]) begin
                send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
            end else begin
                send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
            end
        end
        send_pair(16'sd5, '0, 1'b1);
        // Clean vector right after saturation
        send_pair(16'sd2, '0, 1'b1);

        // Random vectors: slow receiver, then slow sender, then full rate
        send_random_vectors(PHASE_PAIRS);
        send_idle_pct = 83;
        recv_idle_pct <= 13;
        send_random_vectors(PHASE_PAIRS);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_request = 1'b1;
        // Back-to-back single-pair vectors fill the block under the hold
        for (int k = 0; k < HOLD_VECTORS; k++) begin
            send_pair(pick_element(), pick_element(), 1'b1);
        end
        send_random_vectors(PHASE_PAIRS);

        // Drain outstanding results
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
